// ----- hw/rtl/srpq_pkg.sv -----
// ----------------------------------------------------------------------------
// srpq_pkg
// shared types, constants and pointer helpers of the sorted ring priority queue
// ----------------------------------------------------------------------------
package srpq_pkg;

    localparam int DEPTH       = 64;
    localparam int PTR_W       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W       = $clog2(DEPTH + 1);
    localparam int DATA_W      = 32;
    localparam int OPCODE_W    = 2;
    localparam int STATUS_W    = 2;
    localparam int COUNT_OUT_W = 7;

    typedef logic [PTR_W-1:0]    ptr_t;
    typedef logic [CNT_W-1:0]    cnt_t;
    typedef logic [OPCODE_W-1:0] opcode_t;
    typedef logic [STATUS_W-1:0] status_t;

    localparam ptr_t LAST_SLOT  = ptr_t'(DEPTH - 1);
    localparam cnt_t FULL_COUNT = cnt_t'(DEPTH);

    // operation codes
    localparam opcode_t OP_ENQ  = 2'd0;
    localparam opcode_t OP_DEQ  = 2'd1;
    localparam opcode_t OP_FIND = 2'd2;

    // status codes
    localparam status_t ST_DONE  = 2'd0;
    localparam status_t ST_FULL  = 2'd1;
    localparam status_t ST_EMPTY = 2'd2;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic [DATA_W-1:0] pri;
    } entry_t;

    // one write port and one registered read port of the entry store
    typedef struct packed {
        logic   wr_en;
        ptr_t   wr_addr;
        entry_t wr_entry;
        logic   rd_en;
        ptr_t   rd_addr;
    } store_req_t;

    function automatic ptr_t ptr_next(input ptr_t p);
        return (p == LAST_SLOT) ? '0 : ptr_t'(p + 1'b1);
    endfunction

    function automatic ptr_t ptr_prev(input ptr_t p);
        return (p == '0) ? LAST_SLOT : ptr_t'(p - 1'b1);
    endfunction

endpackage

// ----- hw/rtl/srpq_if.sv -----
// ----------------------------------------------------------------------------
// srpq channel interfaces
// command and response channels with valid/ready handshake
// ----------------------------------------------------------------------------
interface srpq_cmd_if import srpq_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [OPCODE_W-1:0] opcode;
    logic [DATA_W-1:0]   item_value;
    logic [DATA_W-1:0]   item_priority;

    modport source (output valid, output opcode, output item_value, output item_priority,
                    input ready);
    modport sink   (input valid, input opcode, input item_value, input item_priority,
                    output ready);
endinterface

interface srpq_rsp_if import srpq_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [STATUS_W-1:0]    status;
    logic                   found;
    logic [DATA_W-1:0]      out_value;
    logic [DATA_W-1:0]      out_priority;
    logic [COUNT_OUT_W-1:0] entry_count;
    logic                   queue_full;
    logic                   queue_empty;

    modport source (output valid, output status, output found, output out_value,
                    output out_priority, output entry_count, output queue_full,
                    output queue_empty, input ready);
    modport sink   (input valid, input status, input found, input out_value,
                    input out_priority, input entry_count, input queue_full,
                    input queue_empty, output ready);
endinterface

// ----- hw/rtl/srpq_store.sv -----
// ----------------------------------------------------------------------------
// srpq_store
// entry memory, one write port and one read port with registered read data
// ----------------------------------------------------------------------------
module srpq_store import srpq_pkg::*;
(
    input  logic       clk,
    input  store_req_t req,
    output entry_t     rd_entry
);

    entry_t mem [DEPTH];
    entry_t rd_entry_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_entry;
        end
        if (req.rd_en)
        begin
            rd_entry_reg <= mem[req.rd_addr];
        end
    end

    assign rd_entry = rd_entry_reg;

endmodule

// ----- hw/rtl/sorted_ring_priority_queue.sv -----
// ----------------------------------------------------------------------------
// sorted_ring_priority_queue
// priority queue held as a sorted circular buffer of DEPTH entries
// ----------------------------------------------------------------------------
// usage
//   cmd carries one item: opcode, item_value, item_priority. rsp returns one
//   item per command: status, found, out_value, out_priority and the count
//   and full/empty flags after the operation.
//   cmd.ready is high only while the sequencer is idle; one command is worked
//   on at a time. all storage goes through one memory with one write and one
//   registered read port.
//   an enqueue moves stored entries one slot back from the tail until the
//   new entry fits and then writes it, a dequeue reads the head entry and
//   a find scans from the head. an enqueue on an empty queue writes its
//   entry directly; a full enqueue, a dequeue or find on an empty queue and
//   other opcodes go straight to the response.
//   sustained rate is set by the insertion shift and the find scan, one
//   entry per cycle through the single memory port.
//   reset empties the queue (head 0, tail DEPTH-1, count 0); the memory is
//   not cleared and needs no clearing pass. a stalled rsp holds its item in
//   the output register; the next command is still accepted and finishes
//   into a staging register, then waits until the output register frees.
// ----------------------------------------------------------------------------
module sorted_ring_priority_queue import srpq_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    srpq_cmd_if.sink       cmd,
    srpq_rsp_if.source     rsp
);

    // sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_ENQ  = 3'd1;   // compare and shift toward head
    localparam logic [2:0] S_FILL = 3'd2;   // drop the new entry at the head
    localparam logic [2:0] S_DEQ  = 3'd3;   // capture head entry
    localparam logic [2:0] S_FIND = 3'd4;   // scan from head
    localparam logic [2:0] S_RESP = 3'd5;   // hand result to the output register

    logic [2:0] state_reg, state_next;
    ptr_t       head_reg, head_next;
    ptr_t       tail_reg, tail_next;
    cnt_t       occ_reg, occ_next;
    ptr_t       idx_reg, idx_next;      // hole position on enqueue, scan pointer on find
    cnt_t       left_reg, left_next;    // entries still to compare on find
    entry_t     key_reg, key_next;      // entry being inserted or value searched

    // staged result
    status_t    st_status_reg, st_status_next;
    logic       st_found_reg, st_found_next;
    entry_t     st_entry_reg, st_entry_next;

    // output register
    logic       out_valid_reg, out_valid_next;
    logic       out_load;
    status_t    out_status_reg;
    logic       out_found_reg;
    entry_t     out_entry_reg;
    cnt_t       out_occ_reg;

    store_req_t req;
    entry_t     rd_entry;
    entry_t     cmd_entry;
    ptr_t       idx_prev;
    logic       cmd_fire;
    logic       new_before;

    srpq_store u_store (
        .clk      (clk),
        .req      (req),
        .rd_entry (rd_entry)
    );

    assign cmd.ready  = (state_reg == S_IDLE);
    assign cmd_fire   = cmd.valid && cmd.ready;
    assign cmd_entry  = '{value: cmd.item_value, pri: cmd.item_priority};
    assign idx_prev   = ptr_prev(idx_reg);
    // compare unit of the insertion shift: new entry strictly ahead of the stored one
    assign new_before = $signed(key_reg.pri) < $signed(rd_entry.pri);

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        occ_next       = occ_reg;
        idx_next       = idx_reg;
        left_next      = left_reg;
        key_next       = key_reg;
        st_status_next = st_status_reg;
        st_found_next  = st_found_reg;
        st_entry_next  = st_entry_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_load       = 1'b0;

        req.wr_en    = 1'b0;
        req.wr_addr  = idx_reg;
        req.wr_entry = key_reg;
        req.rd_en    = 1'b0;
        req.rd_addr  = idx_prev;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_fire)
                begin
                    st_status_next = ST_DONE;
                    st_found_next  = 1'b0;
                    st_entry_next  = '0;
                    state_next     = S_RESP;
                    unique case (cmd.opcode)
                        OP_ENQ:
                        begin
                            key_next = cmd_entry;
                            if (occ_reg == FULL_COUNT)
                            begin
                                st_status_next = ST_FULL;
                            end
                            else
                            begin
                                tail_next = ptr_next(tail_reg);
                                occ_next  = cnt_t'(occ_reg + 1'b1);
                                idx_next  = ptr_next(tail_reg);
                                if (occ_reg == '0)
                                begin
                                    req.wr_en    = 1'b1;
                                    req.wr_addr  = ptr_next(tail_reg);
                                    req.wr_entry = cmd_entry;
                                end
                                else
                                begin
                                    // entry ahead of the new slot is the old tail
                                    req.rd_en   = 1'b1;
                                    req.rd_addr = tail_reg;
                                    state_next  = S_ENQ;
                                end
                            end
                        end
                        OP_DEQ:
                        begin
                            if (occ_reg == '0)
                            begin
                                st_status_next = ST_EMPTY;
                            end
                            else
                            begin
                                req.rd_en   = 1'b1;
                                req.rd_addr = head_reg;
                                head_next   = ptr_next(head_reg);
                                occ_next    = cnt_t'(occ_reg - 1'b1);
                                state_next  = S_DEQ;
                            end
                        end
                        OP_FIND:
                        begin
                            key_next.value = cmd.item_value;
                            if (occ_reg != '0)
                            begin
                                req.rd_en   = 1'b1;
                                req.rd_addr = head_reg;
                                idx_next    = ptr_next(head_reg);
                                left_next   = occ_reg;
                                state_next  = S_FIND;
                            end
                        end
                        default:
                        begin
                            // unused opcode: report count and flags only
                        end
                    endcase
                end
            end
            S_ENQ:
            begin
                req.wr_en = 1'b1;
                if (new_before)
                begin
                    // move the stored entry back one slot into the hole
                    req.wr_entry = rd_entry;
                    idx_next     = idx_prev;
                    if (idx_prev == head_reg)
                    begin
                        state_next = S_FILL;
                    end
                    else
                    begin
                        req.rd_en   = 1'b1;
                        req.rd_addr = ptr_prev(idx_prev);
                    end
                end
                else
                begin
                    state_next = S_RESP;
                end
            end
            S_FILL:
            begin
                req.wr_en  = 1'b1;
                state_next = S_RESP;
            end
            S_DEQ:
            begin
                st_entry_next = rd_entry;
                state_next    = S_RESP;
            end
            S_FIND:
            begin
                if (rd_entry.value == key_reg.value)
                begin
                    st_found_next = 1'b1;
                    state_next    = S_RESP;
                end
                else if (left_reg == cnt_t'(1))
                begin
                    state_next = S_RESP;
                end
                else
                begin
                    req.rd_en   = 1'b1;
                    req.rd_addr = idx_reg;
                    idx_next    = ptr_next(idx_reg);
                    left_next   = cnt_t'(left_reg - 1'b1);
                end
            end
            S_RESP:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            tail_reg      <= LAST_SLOT;
            occ_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            occ_reg       <= occ_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg       <= idx_next;
        left_reg      <= left_next;
        key_reg       <= key_next;
        st_status_reg <= st_status_next;
        st_found_reg  <= st_found_next;
        st_entry_reg  <= st_entry_next;
        if (out_load)
        begin
            out_status_reg <= st_status_reg;
            out_found_reg  <= st_found_reg;
            out_entry_reg  <= st_entry_reg;
            out_occ_reg    <= occ_reg;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.status       = out_status_reg;
    assign rsp.found        = out_found_reg;
    assign rsp.out_value    = out_entry_reg.value;
    assign rsp.out_priority = out_entry_reg.pri;
    assign rsp.entry_count  = COUNT_OUT_W'(out_occ_reg);
    assign rsp.queue_full   = (out_occ_reg == FULL_COUNT);
    assign rsp.queue_empty  = (out_occ_reg == '0);

    // count never exceeds the ring size
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= FULL_COUNT)
        else $error("occupancy above depth");

    // accepted enqueue on a non-full queue grows the count by one
    a_enq_count: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_fire && cmd.opcode == OP_ENQ && occ_reg != FULL_COUNT)
        |=> occ_reg == cnt_t'($past(occ_reg) + 1'b1))
        else $error("enqueue count update wrong");

    // accepted dequeue on a non-empty queue moves the head and drops the count
    a_deq_head: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_fire && cmd.opcode == OP_DEQ && occ_reg != '0)
        |=> (head_reg == ptr_next($past(head_reg)))
            && (occ_reg == cnt_t'($past(occ_reg) - 1'b1)))
        else $error("dequeue head or count update wrong");

    // the shift walk never passes the head
    a_enq_walk: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ENQ) |-> (idx_reg != head_reg))
        else $error("insertion shift reached the head slot");

endmodule

// ----- bench/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// drives enqueue, dequeue, find and unused-opcode items into the sorted ring priority
// queue and checks every response against a shadow copy of the queue contents or a fixed expected response
// ----------------------------------------------------------------------------
module testbench;
    import srpq_pkg::*;

    // opcode that the queue answers without touching its contents
    localparam opcode_t OP_NONE = 2'd3;

    localparam int RANDOM_ITEMS = 650;
    localparam int DRAIN_CYCLES = DEPTH + 40;
    localparam int MAX_REPORTS  = 10;

    typedef struct packed {
        status_t                status;
        logic                   found;
        logic [DATA_W-1:0]      value;
        logic [DATA_W-1:0]      pri;
        logic [COUNT_OUT_W-1:0] count;
        logic                   full;
        logic                   empty;
    } rsp_t;

    typedef struct {
        opcode_t           op;
        logic [DATA_W-1:0] value;
        logic [DATA_W-1:0] pri;
        bit                fixed;
        rsp_t              want;
    } stim_row_t;

    logic clk;
    logic rst_n;

    srpq_cmd_if cmd ();
    srpq_rsp_if rsp ();

    sorted_ring_priority_queue dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .rsp   (rsp)
    );

    always #2 clk = ~clk;

    // shadow copy of the queue, updated at each accepted command
    logic [DATA_W-1:0] shadow_val [DEPTH];
    logic [DATA_W-1:0] shadow_pri [DEPTH];
    int                shadow_head;
    int                shadow_tail;
    int                shadow_occ;

    rsp_t      pending_results [$];
    stim_row_t directed_rows [$];

    int mismatches;
    int counted_items;
    bit quiet_segment;
    int rsp_stall_left;

    // applies one command to the shadow queue and returns the response it causes
    function automatic rsp_t shadow_step(opcode_t op, logic [DATA_W-1:0] v,
                                         logic [DATA_W-1:0] p);
        rsp_t              r;
        int                idx;
        int                prv;
        bit                moving;
        logic [DATA_W-1:0] tv;
        logic [DATA_W-1:0] tp;
        r = '0;
        case (op)
            OP_ENQ:
            begin
                if (shadow_occ >= DEPTH)
                begin
                    r.status = ST_FULL;
                end
                else
                begin
                    shadow_tail = (shadow_tail + 1) % DEPTH;
                    shadow_val[shadow_tail] = v;
                    shadow_pri[shadow_tail] = p;
                    shadow_occ++;
                    idx = shadow_tail;
                    moving = 1'b1;
                    // bubble toward the head past strictly greater priorities
                    while (moving && idx != shadow_head)
                    begin
                        prv = (idx + DEPTH - 1) % DEPTH;
                        if ($signed(shadow_pri[idx]) < $signed(shadow_pri[prv]))
                        begin
                            tv = shadow_val[idx];
                            tp = shadow_pri[idx];
                            shadow_val[idx] = shadow_val[prv];
                            shadow_pri[idx] = shadow_pri[prv];
                            shadow_val[prv] = tv;
                            shadow_pri[prv] = tp;
                            idx = prv;
                        end
                        else
                        begin
                            moving = 1'b0;
                        end
                    end
                end
            end
            OP_DEQ:
            begin
                if (shadow_occ == 0)
                begin
                    r.status = ST_EMPTY;
                end
                else
                begin
                    r.value = shadow_val[shadow_head];
                    r.pri   = shadow_pri[shadow_head];
                    shadow_head = (shadow_head + 1) % DEPTH;
                    shadow_occ--;
                end
            end
            OP_FIND:
            begin
                for (int i = 0; i < shadow_occ; i++)
                    if (shadow_val[(shadow_head + i) % DEPTH] == v)
                        r.found = 1'b1;
            end
            default: ;
        endcase
        r.count = COUNT_OUT_W'(shadow_occ);
        r.full  = (shadow_occ == DEPTH);
        r.empty = (shadow_occ == 0);
        return r;
    endfunction

    // mostly short gaps, a few long ones, none in quiet segments
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (quiet_segment || r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    // small values collide often, some are drawn from what the queue holds
    function automatic logic [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 2))
            0: return $urandom_range(0, 15);
            1: return $urandom;
            default:
            begin
                if (shadow_occ == 0)
                    return $urandom;
                return shadow_val[(shadow_head + $urandom_range(0, shadow_occ - 1)) % DEPTH];
            end
        endcase
    endfunction

    // narrow range gives many equal priorities to test arrival order
    function automatic logic [DATA_W-1:0] pick_priority();
        case ($urandom_range(0, 3))
            0, 1: return DATA_W'($urandom_range(0, 6)) - DATA_W'(3);
            2: return $urandom;
            default: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
        endcase
    endfunction

    function automatic void plan(opcode_t op, logic [DATA_W-1:0] v,
                                 logic [DATA_W-1:0] p);
        stim_row_t row;
        row.op = op;
        row.value = v;
        row.pri = p;
        row.fixed = 1'b0;
        row.want = '0;
        directed_rows.push_back(row);
    endfunction

    function automatic void plan_fixed(opcode_t op, logic [DATA_W-1:0] v,
                                       logic [DATA_W-1:0] p, rsp_t want);
        stim_row_t row;
        row.op = op;
        row.value = v;
        row.pri = p;
        row.fixed = 1'b1;
        row.want = want;
        directed_rows.push_back(row);
    endfunction

    // presents one item, waits for it to be taken, then records the expectation
    task automatic send_item(opcode_t op, logic [DATA_W-1:0] v, logic [DATA_W-1:0] p,
                             bit fixed, rsp_t want);
        int   gap;
        rsp_t predicted;
        gap = idle_len();
        if (gap > 0)
        begin
            cmd.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd.valid         <= 1'b1;
        cmd.opcode        <= op;
        cmd.item_value    <= v;
        cmd.item_priority <= p;
        @(posedge clk);
        while (!cmd.ready)
            @(posedge clk);
        predicted = shadow_step(op, v, p);
        pending_results.push_back(fixed ? want : predicted);
        if (op != OP_NONE)
            counted_items++;
    endtask

    // receiver side stalls
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            rsp.ready <= 1'b0;
            rsp_stall_left = 0;
        end
        else if (rsp_stall_left > 0)
        begin
            rsp_stall_left--;
            rsp.ready <= 1'b0;
        end
        else
        begin
            rsp.ready <= 1'b1;
            if ($urandom_range(0, 3) == 0)
                rsp_stall_left = idle_len();
        end
    end

    // response checker
    always @(posedge clk)
    begin
        rsp_t got;
        rsp_t want;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            got = '{rsp.status, rsp.found, rsp.out_value, rsp.out_priority,
                    rsp.entry_count, rsp.queue_full, rsp.queue_empty};
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected response st=%0d cnt=%0d", got.status, got.count);
            end
            else
            begin
                want = pending_results.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                    begin
                        $display("mismatch exp: st=%0d fnd=%0b val=%h pri=%h cnt=%0d f=%0b e=%0b",
                                 want.status, want.found, want.value, want.pri,
                                 want.count, want.full, want.empty);
                        $display("         got: st=%0d fnd=%0b val=%h pri=%h cnt=%0d f=%0b e=%0b",
                                 got.status, got.found, got.value, got.pri,
                                 got.count, got.full, got.empty);
                    end
                end
            end
        end
    end

    initial
    begin
        #2000000;
        $display("** sorted_ring_priority_queue: FAILED **");
        $finish;
    end

    initial
    begin
        int kind;
        int n;
        int r;
        opcode_t op;

        clk = 1'b0;
        rst_n = 1'b0;
        cmd.valid = 1'b0;
        cmd.opcode = OP_ENQ;
        cmd.item_value = '0;
        cmd.item_priority = '0;
        mismatches = 0;
        counted_items = 0;
        quiet_segment = 1'b0;
        shadow_head = 0;
        shadow_tail = DEPTH - 1;
        shadow_occ = 0;
        for (int i = 0; i < DEPTH; i++)
        begin
            shadow_val[i] = '0;
            shadow_pri[i] = '0;
        end

        // fields: status, found, value, priority, count, full, empty
        plan_fixed(OP_DEQ,  32'h0, 32'h0, '{ST_EMPTY, 1'b0, 32'h0, 32'h0, 7'd0, 1'b0, 1'b1});
        plan_fixed(OP_FIND, 32'h0, 32'h0, '{ST_DONE, 1'b0, 32'h0, 32'h0, 7'd0, 1'b0, 1'b1});
        plan_fixed(OP_NONE, 32'hffff_ffff, 32'hffff_ffff,
                   '{ST_DONE, 1'b0, 32'h0, 32'h0, 7'd0, 1'b0, 1'b1});
        plan_fixed(OP_ENQ, 32'h7fff_ffff, 32'h7fff_ffff,
                   '{ST_DONE, 1'b0, 32'h0, 32'h0, 7'd1, 1'b0, 1'b0});
        plan_fixed(OP_ENQ, 32'h8000_0000, 32'h8000_0000,
                   '{ST_DONE, 1'b0, 32'h0, 32'h0, 7'd2, 1'b0, 1'b0});
        plan_fixed(OP_ENQ, 32'h0, 32'h0, '{ST_DONE, 1'b0, 32'h0, 32'h0, 7'd3, 1'b0, 1'b0});
        plan_fixed(OP_ENQ, 32'hffff_ffff, 32'hffff_ffff,
                   '{ST_DONE, 1'b0, 32'h0, 32'h0, 7'd4, 1'b0, 1'b0});
        plan_fixed(OP_FIND, 32'h8000_0000, 32'h5555_aaaa,
                   '{ST_DONE, 1'b1, 32'h0, 32'h0, 7'd4, 1'b0, 1'b0});
        plan_fixed(OP_FIND, 32'h1234_5678, 32'haaaa_5555,
                   '{ST_DONE, 1'b0, 32'h0, 32'h0, 7'd4, 1'b0, 1'b0});
        // most negative priority leaves first, then minus one
        plan_fixed(OP_DEQ, 32'hffff_ffff, 32'hffff_ffff,
                   '{ST_DONE, 1'b0, 32'h8000_0000, 32'h8000_0000, 7'd3, 1'b0, 1'b0});
        plan_fixed(OP_DEQ, 32'h0, 32'h0,
                   '{ST_DONE, 1'b0, 32'hffff_ffff, 32'hffff_ffff, 7'd2, 1'b0, 1'b0});
        // equal priorities must come out in arrival order
        plan(OP_ENQ, 32'd11, 32'd5);
        plan(OP_ENQ, 32'd22, 32'd5);
        plan(OP_ENQ, 32'd33, 32'd5);
        plan(OP_ENQ, 32'd44, 32'd4);
        repeat (5) plan(OP_DEQ, 32'h0, 32'h0);
        plan_fixed(OP_DEQ, 32'h0, 32'h0,
                   '{ST_DONE, 1'b0, 32'h7fff_ffff, 32'h7fff_ffff, 7'd0, 1'b0, 1'b1});
        plan_fixed(OP_DEQ, 32'h0, 32'h0, '{ST_EMPTY, 1'b0, 32'h0, 32'h0, 7'd0, 1'b0, 1'b1});
        plan_fixed(OP_FIND, 32'h7fff_ffff, 32'h0,
                   '{ST_DONE, 1'b0, 32'h0, 32'h0, 7'd0, 1'b0, 1'b1});
        plan_fixed(OP_ENQ, 32'd5, -32'sd7, '{ST_DONE, 1'b0, 32'h0, 32'h0, 7'd1, 1'b0, 1'b0});
        plan_fixed(OP_NONE, 32'h0, 32'h0, '{ST_DONE, 1'b0, 32'h0, 32'h0, 7'd1, 1'b0, 1'b0});

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_item(directed_rows[i].op, directed_rows[i].value, directed_rows[i].pri,
                      directed_rows[i].fixed, directed_rows[i].want);

        // random segments: fill to full and past it, drain to empty and past it,
        // or a mixed run; the head walks around the ring many times so the
        // insertion shift crosses slot zero
        counted_items = 0;
        while (counted_items < RANDOM_ITEMS)
        begin
            kind = $urandom_range(0, 9);
            quiet_segment = ($urandom_range(0, 4) == 0);
            if (kind < 2)
            begin
                n = DEPTH - shadow_occ + $urandom_range(1, 3);
                repeat (n) send_item(OP_ENQ, pick_value(), pick_priority(), 1'b0, '0);
            end
            else if (kind < 4)
            begin
                n = shadow_occ + $urandom_range(1, 2);
                repeat (n) send_item(OP_DEQ, $urandom, $urandom, 1'b0, '0);
            end
            else
            begin
                n = $urandom_range(10, 50);
                repeat (n)
                begin
                    r = $urandom_range(0, 99);
                    if (r < 40)
                        op = OP_ENQ;
                    else if (r < 70)
                        op = OP_DEQ;
                    else if (r < 95)
                        op = OP_FIND;
                    else
                        op = OP_NONE;
                    send_item(op, pick_value(), pick_priority(), 1'b0, '0);
                end
            end
        end
        cmd.valid <= 1'b0;
        quiet_segment = 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && pending_results.size() == 0)
            $display("** sorted_ring_priority_queue: PASSED **");
        else
            $display("** sorted_ring_priority_queue: FAILED **");
        $finish;
    end

endmodule
